### rtl/exti_pkg.sv
// ----------------------------------------------------------------------------
// exti_pkg
// shared types, codes and request grouping for the external interrupt block
// ----------------------------------------------------------------------------
package exti_pkg;

    localparam int NUM_LINES   = 19;
    localparam int NUM_REQ     = 10;
    localparam int CFG_IDX_W   = 1;

    // request grouping boundaries
    localparam int SOLO_LAST   = 4;
    localparam int GRPA_FIRST  = 5;
    localparam int GRPA_LAST   = 9;
    localparam int GRPB_FIRST  = 10;
    localparam int GRPB_LAST   = 15;
    localparam int TAIL_FIRST  = 16;
    localparam int TAIL_LAST   = 18;

    localparam int REQ_GRPA    = 5;
    localparam int REQ_GRPB    = 6;
    localparam int REQ_TAIL    = 7;

    typedef logic [NUM_LINES-1:0] t_lines;
    typedef logic [NUM_REQ-1:0]   t_req;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_TRIGGER = 2'd2,
        CMD_MASK    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISING  = 1'b0,
        REG_FALLING = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd   command;
        t_lines line_levels;
        t_lines write_value;
    } t_in_item;

    typedef struct packed {
        t_lines pending_flags;
        t_req   irq_request;
    } t_out_item;

    // fold unmasked pending lines onto the request outputs
    function automatic t_req request_lines(input t_lines active);
        t_req req;
        req = '0;
        req[SOLO_LAST:0]                  = active[SOLO_LAST:0];
        req[REQ_GRPA]                     = |active[GRPA_LAST:GRPA_FIRST];
        req[REQ_GRPB]                     = |active[GRPB_LAST:GRPB_FIRST];
        req[NUM_REQ-1:REQ_TAIL]           = active[TAIL_LAST:TAIL_FIRST];
        return req;
    endfunction

endpackage

### rtl/exti_edge_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// exti_edge_interrupt_controller_core
// 19-line edge-triggered external interrupt controller with 10 request outputs
// ----------------------------------------------------------------------------
//  channel   signals                                    carries
//  in        i_in_valid / o_in_ready / i_in_item        command item
//  out       o_out_valid / i_out_ready / o_out_item     pending flags, requests
//  cfg       i_cfg_we / i_cfg_index / i_cfg_wdata       edge enable registers
//
//  one item per cycle sustained while results are taken; an accepted item
//  is loaded into the input register and then into the result register once
//  that register has space; the result is offered from there
//  pending/mask/level updates happen as an item moves to the result register
//  reset is synchronous and active low; it clears state, enables and valids
//  a stalled result holds its register; the input register fills behind it
//  and ready drops only when both registers are full
// ----------------------------------------------------------------------------
module exti_edge_interrupt_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  exti_pkg::t_in_item             i_in_item,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output exti_pkg::t_out_item            o_out_item,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [exti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  exti_pkg::t_lines               i_cfg_wdata
);
    import exti_pkg::*;

    logic      stg_valid;
    t_in_item  stg_item;
    logic      out_space;
    logic      fire;
    t_out_item result;

    // item moves into evaluation when the result register can take it
    assign fire = stg_valid && out_space;

    exti_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_take  (fire),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    // edge detect, pending update and request folding
    exti_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (stg_item),
        .o_result    (result)
    );

    exti_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_item  (result),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

### rtl/exti_in_stage.sv
// ----------------------------------------------------------------------------
// exti_in_stage
// input register: holds one command item until the evaluation stage takes it
// ----------------------------------------------------------------------------
module exti_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  exti_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output exti_pkg::t_in_item o_item
);
    import exti_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // free when empty or emptying this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/exti_eval.sv
// ----------------------------------------------------------------------------
// exti_eval
// edge detection, pending/mask state and request folding for one item
// ----------------------------------------------------------------------------
module exti_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [exti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  exti_pkg::t_lines            i_cfg_wdata,
    input  logic                        i_fire,
    input  exti_pkg::t_in_item          i_item,
    output exti_pkg::t_out_item         o_result
);
    import exti_pkg::*;

    t_lines r_rise_en;
    t_lines r_fall_en;
    t_lines r_prev;
    t_lines r_pend;
    t_lines r_mask;

    t_lines n_prev;
    t_lines n_pend;
    t_lines n_mask;

    always_comb begin
        n_prev = r_prev;
        n_pend = r_pend;
        n_mask = r_mask;
        case (i_item.command)
            CMD_SAMPLE: begin
                n_pend = r_pend
                       | (i_item.line_levels & ~r_prev & r_rise_en)
                       | (~i_item.line_levels & r_prev & r_fall_en);
                n_prev = i_item.line_levels;
            end
            CMD_CLEAR: begin
                n_pend = r_pend & ~i_item.write_value;
            end
            CMD_TRIGGER: begin
                n_pend = r_pend | i_item.write_value;
            end
            CMD_MASK: begin
                n_mask = i_item.write_value;
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    assign o_result.pending_flags = n_pend;
    assign o_result.irq_request   = request_lines(n_pend & n_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_pend <= '0;
            r_mask <= '0;
        end else if (i_fire) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_en <= '0;
            r_fall_en <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RISING:  r_rise_en <= i_cfg_wdata;
                REG_FALLING: r_fall_en <= i_cfg_wdata;
                default:     r_rise_en <= r_rise_en;
            endcase
        end
    end

endmodule

### rtl/exti_out_stage.sv
// ----------------------------------------------------------------------------
// exti_out_stage
// result register: holds one result item until the consumer takes it
// ----------------------------------------------------------------------------
module exti_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  exti_pkg::t_out_item i_item,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output exti_pkg::t_out_item o_item
);
    import exti_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/exti_checker.sv
// ----------------------------------------------------------------------------
// exti_checker
// port-level checks on the interrupt controller, bound to the top level
// ----------------------------------------------------------------------------
module exti_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  exti_pkg::t_in_item             i_in_item,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  exti_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [exti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  exti_pkg::t_lines               i_cfg_wdata
);
    import exti_pkg::*;

    t_lines pf;
    t_req   rq;

    assign pf = o_out_item.pending_flags;
    assign rq = o_out_item.irq_request;

    // nothing to show straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a request is only raised by a pending line of its group
    a_req_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((rq[SOLO_LAST:0] & ~pf[SOLO_LAST:0]) == '0)
            && (!rq[REQ_GRPA] || (|pf[GRPA_LAST:GRPA_FIRST]))
            && (!rq[REQ_GRPB] || (|pf[GRPB_LAST:GRPB_FIRST]))
            && ((rq[NUM_REQ-1:REQ_TAIL] & ~pf[TAIL_LAST:TAIL_FIRST]) == '0))
        else $error("request without pending line");

    // a fresh result follows an item accepted into the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without an item");

endmodule

bind exti_edge_interrupt_controller_core exti_checker u_exti_checker (.*);
